// ===== src/tomq_pkg.sv =====
`default_nettype none
package tomq_pkg;

	localparam int NUM_PRODUCERS = 8;
	localparam int FIFO_DEPTH    = 16;
	localparam int DATA_WIDTH    = 32;

	// port widths fixed by the interface
	localparam int PID_W    = 3;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int ENABLE_W = 8;
	localparam int SLOTS    = 8;   // leaves of the head-stamp compare tree

	localparam int STAMP_W   = 64;
	localparam int PROD_W    = (NUM_PRODUCERS > 1) ? $clog2(NUM_PRODUCERS) : 1;
	localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
	localparam int ADDR_W    = PROD_W + PTR_W;
	localparam int MEM_DEPTH = NUM_PRODUCERS << PTR_W;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CMD_ENQ,
		CMD_DEQ,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [PID_W-1:0]   pid;
		logic [WORD_W-1:0]  data;
	} cmd_t;

	typedef struct packed {
		logic               vld;
		logic [PID_W-1:0]   idx;
		logic [STAMP_W-1:0] stamp;
	} cand_t;

	// older of two candidates; the left one wins a tie
	function automatic cand_t pick_older(input cand_t a, input cand_t b);
		cand_t r;
		if (b.vld && (!a.vld || (b.stamp < a.stamp)))
			r = b;
		else
			r = a;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/tomq_front.sv =====
`default_nettype none
module tomq_front import tomq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire logic              req_type,
	input  wire logic [PID_W-1:0]  producer_id,
	input  wire logic [WORD_W-1:0] data_in,
	output      logic              cmd_valid,
	input  wire logic              cmd_ready,
	output      cmd_t              cmd
);

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	// classify the request on the way in
	always_comb begin
		cls.pid  = producer_id;
		cls.data = data_in;
		if (req_type == REQ_DEQ)
			cls.kind = CMD_DEQ;
		else if ({1'b0, producer_id} >= (PID_W + 1)'(NUM_PRODUCERS))
			cls.kind = CMD_REJECT;
		else
			cls.kind = CMD_ENQ;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= cls;
	end

endmodule
`default_nettype wire

// ===== src/tomq_back.sv =====
`default_nettype none
module tomq_back import tomq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output      logic                cmd_ready,
	input  wire cmd_t                cmd,
	input  wire logic                cfg_valid,
	input  wire logic [ENABLE_W-1:0] cfg_data,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [WORD_W-1:0]   data_out,
	output      logic [PID_W-1:0]    source_producer,
	output      logic [STATUS_W-1:0] status
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEL,
		ST_FILL
	} state_t;

	state_t                  state_q;
	logic                    out_valid_q;
	logic [WORD_W-1:0]       data_out_q;
	logic [PID_W-1:0]        src_q;
	logic [STATUS_W-1:0]     status_q;
	logic [ENABLE_W-1:0]     enable_q;
	logic [STAMP_W-1:0]      stamp_q;
	logic [CNT_W-1:0]        cnt_q  [NUM_PRODUCERS];
	logic [PTR_W-1:0]        rp_q   [NUM_PRODUCERS];
	logic [PTR_W-1:0]        wp_q   [NUM_PRODUCERS];
	logic [STAMP_W-1:0]      head_stamp_q [NUM_PRODUCERS];
	logic [DATA_WIDTH-1:0]   head_data_q  [NUM_PRODUCERS];
	logic [DATA_WIDTH-1:0]   mem_data [MEM_DEPTH];
	logic [STAMP_W-1:0]      mem_stamp [MEM_DEPTH];
	logic [DATA_WIDTH-1:0]   rd_data_q;
	logic [STAMP_W-1:0]      rd_stamp_q;
	logic [PROD_W-1:0]       fill_pid_q;
	cand_t                   win_s1 [4];

	cand_t                   cand [SLOTS];
	cand_t                   lvl1 [4];
	cand_t                   best;
	logic [PROD_W-1:0]       pid_idx;
	logic [PROD_W-1:0]       best_idx;
	logic                    slot_free;
	logic                    pop;
	logic                    enq_ok;
	logic                    sel_go;
	logic                    refill;
	logic                    res_load;
	logic [PTR_W-1:0]        wp_next;
	logic [PTR_W-1:0]        rp_next;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(FIFO_DEPTH - 1))
			r = '0;
		else
			r = p + PTR_W'(1);
		return r;
	endfunction

	assign slot_free = !out_valid_q || out_ready;
	assign cmd_ready = (state_q == ST_IDLE) && slot_free;
	assign pop       = cmd_valid && cmd_ready;
	assign pid_idx   = cmd.pid[PROD_W-1:0];
	assign enq_ok    = (cmd.kind == CMD_ENQ) && (cnt_q[pid_idx] != CNT_W'(FIFO_DEPTH));
	assign wp_next   = ptr_inc(wp_q[pid_idx]);

	// first tree level over the live heads, registered when a dequeue is taken
	always_comb begin
		for (int p = 0; p < SLOTS; p++) begin
			cand[p].idx = PID_W'(p);
			if (p < NUM_PRODUCERS) begin
				cand[p].vld   = enable_q[p] && (cnt_q[PROD_W'(p)] != '0);
				cand[p].stamp = head_stamp_q[PROD_W'(p)];
			end else begin
				cand[p].vld   = 1'b0;
				cand[p].stamp = '0;
			end
		end
		for (int i = 0; i < 4; i++)
			lvl1[i] = pick_older(cand[2*i], cand[2*i+1]);
	end

	assign best     = pick_older(pick_older(win_s1[0], win_s1[1]),
				pick_older(win_s1[2], win_s1[3]));
	assign best_idx = best.idx[PROD_W-1:0];
	assign rp_next  = ptr_inc(rp_q[best_idx]);
	assign sel_go   = (state_q == ST_SEL) && slot_free;
	assign refill   = sel_go && best.vld && (cnt_q[best_idx] > CNT_W'(1));
	assign res_load = (pop && (cmd.kind != CMD_DEQ)) || sel_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			data_out_q  <= '0;
			src_q       <= '0;
			status_q    <= STATUS_DONE;
			enable_q    <= '1;
			stamp_q     <= STAMP_W'(1);
			fill_pid_q  <= '0;
			for (int p = 0; p < NUM_PRODUCERS; p++) begin
				cnt_q[p] <= '0;
				rp_q[p]  <= '0;
				wp_q[p]  <= '0;
			end
			for (int i = 0; i < 4; i++)
				win_s1[i] <= '0;
		end else begin
			if (cfg_valid)
				enable_q <= cfg_data;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (cmd.kind) inside
							CMD_DEQ: begin
								for (int i = 0; i < 4; i++)
									win_s1[i] <= lvl1[i];
								state_q <= ST_SEL;
							end
							CMD_ENQ, CMD_REJECT: begin
								data_out_q  <= '0;
								src_q       <= cmd.pid;
								if (enq_ok) begin
									status_q         <= STATUS_DONE;
									stamp_q          <= stamp_q + STAMP_W'(1);
									wp_q[pid_idx]    <= wp_next;
									cnt_q[pid_idx]   <= cnt_q[pid_idx] + CNT_W'(1);
								end else begin
									status_q <= STATUS_FULL;
								end
							end
							default: begin
								data_out_q  <= '0;
								src_q       <= cmd.pid;
								status_q    <= STATUS_FULL;
							end
						endcase
					end
				end
				ST_SEL: begin
					if (sel_go) begin
						if (best.vld) begin
							data_out_q      <= WORD_W'(head_data_q[best_idx]);
							src_q           <= best.idx;
							status_q        <= STATUS_DONE;
							rp_q[best_idx]  <= rp_next;
							cnt_q[best_idx] <= cnt_q[best_idx] - CNT_W'(1);
							fill_pid_q      <= best_idx;
							state_q         <= refill ? ST_FILL : ST_IDLE;
						end else begin
							data_out_q <= '0;
							src_q      <= '0;
							status_q   <= STATUS_EMPTY;
							state_q    <= ST_IDLE;
						end
					end
				end
				ST_FILL: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// entry RAM, head registers and the refill read
	always_ff @(posedge clk) begin
		if (pop && enq_ok) begin
			mem_data[{pid_idx, wp_q[pid_idx]}]  <= DATA_WIDTH'(cmd.data);
			mem_stamp[{pid_idx, wp_q[pid_idx]}] <= stamp_q;
			if (cnt_q[pid_idx] == '0) begin
				head_data_q[pid_idx]  <= DATA_WIDTH'(cmd.data);
				head_stamp_q[pid_idx] <= stamp_q;
			end
		end
		if (refill) begin
			rd_data_q  <= mem_data[{best_idx, rp_next}];
			rd_stamp_q <= mem_stamp[{best_idx, rp_next}];
		end
		if (state_q == ST_FILL) begin
			head_data_q[fill_pid_q]  <= rd_data_q;
			head_stamp_q[fill_pid_q] <= rd_stamp_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign data_out        = data_out_q;
	assign source_producer = src_q;
	assign status          = status_q;

endmodule
`default_nettype wire

// ===== src/timestamp_ordered_multi_queue_unit.sv =====
// Timestamp-ordered multi-producer queue. Eight producer FIFOs of sixteen words share
// one entry RAM; every stored word carries a 64-bit stamp from a counter that starts at
// one. An enqueue (req_type 0) appends data_in to the FIFO named by producer_id and
// returns status 0, or status 2 if that FIFO is full. A dequeue (req_type 1) removes the
// oldest head among the FIFOs whose producer_enable bit is set, returning its word and
// producer number, or status 1 with zeros when none holds anything. Every request gives
// exactly one result word. A two-word command queue decouples the input from the
// execution engine, and a result register decouples the engine from the output. In the
// engine an enqueue is handled from the idle state; a dequeue goes through the head-stamp
// compare tree, then selection, and a refill step when the chosen FIFO still holds
// words, because the next head comes back through the entry RAM's single registered
// read port. producer_enable resets to all ones and is written through the cfg channel,
// which is always ready; write it only while no request is in flight.
`default_nettype none
module timestamp_ordered_multi_queue_unit import tomq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic                req_type,
	input  wire logic [PID_W-1:0]    producer_id,
	input  wire logic [WORD_W-1:0]   data_in,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [WORD_W-1:0]   data_out,
	output      logic [PID_W-1:0]    source_producer,
	output      logic [STATUS_W-1:0] status,
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [ENABLE_W-1:0] cfg_data
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// the enable register takes a word on any cycle
	assign cfg_ready = 1'b1;

	// front: accept and classify requests, hold up to two
	tomq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.producer_id (producer_id),
		.data_in     (data_in),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd)
	);

	// back: FIFO bookkeeping, oldest-head search, result register
	tomq_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.cmd             (cmd),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.data_out        (data_out),
		.source_producer (source_producer),
		.status          (status)
	);

endmodule
`default_nettype wire

// ===== src/tomq_checker.sv =====
`default_nettype none
module tomq_checker import tomq_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [WORD_W-1:0]   data_out,
	input wire logic [PID_W-1:0]    source_producer,
	input wire logic [STATUS_W-1:0] status
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out)
			&& $stable(source_producer) && $stable(status))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_DONE) || (status == STATUS_EMPTY)
			|| (status == STATUS_FULL))
		else $error("status code out of range");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_EMPTY) |-> (data_out == '0)
			&& (source_producer == '0))
		else $error("empty dequeue carries data");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STATUS_FULL) |-> (data_out == '0))
		else $error("rejected enqueue carries data");

endmodule

bind timestamp_ordered_multi_queue_unit tomq_checker u_tomq_checker (.*);
`default_nettype wire

// ===== sim/timestamp_ordered_multi_queue_unit_test.sv =====
`default_nettype none
module timestamp_ordered_multi_queue_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tomq_pkg::*;

	// cycles with no word moving on any channel before the run is abandoned;
	// well above the receiver hold-off plus the longest sender gap and stall
	localparam int WATCHDOG_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES    = 300;
	localparam int DRAIN_PAUSE_CYCLES = 12;

	typedef struct {
		logic [WORD_W-1:0]   data;
		logic [PID_W-1:0]    src;
		logic [STATUS_W-1:0] st;
	} queue_result_t;

	// ------------------------------------------------------------------
	// DUT connections; every input starts at a known value
	// ------------------------------------------------------------------
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                req_type    = REQ_ENQ;
	logic [PID_W-1:0]    producer_id = '0;
	logic [WORD_W-1:0]   data_in     = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [WORD_W-1:0]   data_out;
	logic [PID_W-1:0]    source_producer;
	logic [STATUS_W-1:0] status;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic [ENABLE_W-1:0] cfg_data    = '0;

	timestamp_ordered_multi_queue_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.producer_id     (producer_id),
		.data_in         (data_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.data_out        (data_out),
		.source_producer (source_producer),
		.status          (status),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the queue state: one FIFO per producer, each entry holding
	// its word and the stamp it was given on entry
	// ------------------------------------------------------------------
	logic [WORD_W-1:0]   shadow_word  [NUM_PRODUCERS][FIFO_DEPTH];
	logic [STAMP_W-1:0]  shadow_stamp [NUM_PRODUCERS][FIFO_DEPTH];
	int unsigned         shadow_rd    [NUM_PRODUCERS];
	int unsigned         shadow_wr    [NUM_PRODUCERS];
	int unsigned         shadow_fill  [NUM_PRODUCERS];
	logic [STAMP_W-1:0]  next_stamp    = 64'd1;
	logic [ENABLE_W-1:0] enable_shadow = 8'hFF;

	queue_result_t pending_results[$];

	int error_count        = 0;
	int enq_done_count     = 0;
	int enq_full_count     = 0;
	int deq_done_count     = 0;
	int deq_empty_count    = 0;
	int cfg_write_count    = 0;
	int input_stall_cycles = 0;

	// sender and receiver pacing
	bit          tx_eager   = 1'b0;
	logic        rx_eager   = 1'b0;
	logic        rx_holding = 1'b0;
	int unsigned rx_stall_left = 0;
	int unsigned rx_roll;
	event        start_hold_off;

	initial begin
		for (int p = 0; p < NUM_PRODUCERS; p++) begin
			shadow_rd[p]   = 0;
			shadow_wr[p]   = 0;
			shadow_fill[p] = 0;
		end
	end

	// Work out the result of one accepted request and advance the shadow state.
	// An enqueue stamps its word unless the FIFO is full; a dequeue takes the
	// head with the smallest stamp among enabled, non-empty FIFOs, the lowest
	// producer winning a tie.
	function automatic queue_result_t predict_request(input logic kind,
			input logic [PID_W-1:0] pid, input logic [WORD_W-1:0] word);
		queue_result_t      res;
		bit                 found;
		int unsigned        best;
		logic [STAMP_W-1:0] best_stamp;
		logic [STAMP_W-1:0] head_stamp;
		found      = 1'b0;
		best       = 0;
		best_stamp = '0;
		if (kind == REQ_ENQ) begin
			res.data = '0;
			res.src  = pid;
			if (int'(pid) >= NUM_PRODUCERS || shadow_fill[pid] >= FIFO_DEPTH) begin
				res.st = STATUS_FULL;
			end else begin
				shadow_word[pid][shadow_wr[pid]]  = word;
				shadow_stamp[pid][shadow_wr[pid]] = next_stamp;
				next_stamp       = next_stamp + 1'b1;
				shadow_wr[pid]   = (shadow_wr[pid] + 1) % FIFO_DEPTH;
				shadow_fill[pid] = shadow_fill[pid] + 1;
				res.st = STATUS_DONE;
			end
			return res;
		end
		for (int p = 0; p < NUM_PRODUCERS; p++) begin
			if (enable_shadow[p] && shadow_fill[p] != 0) begin
				head_stamp = shadow_stamp[p][shadow_rd[p]];
				if (!found || head_stamp < best_stamp) begin
					found      = 1'b1;
					best       = p;
					best_stamp = head_stamp;
				end
			end
		end
		if (!found) begin
			res.data = '0;
			res.src  = '0;
			res.st   = STATUS_EMPTY;
		end else begin
			res.data = shadow_word[best][shadow_rd[best]];
			res.src  = PID_W'(best);
			res.st   = STATUS_DONE;
			shadow_rd[best]   = (shadow_rd[best] + 1) % FIFO_DEPTH;
			shadow_fill[best] = shadow_fill[best] - 1;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: check the outgoing word before recording the incoming one,
	// so a stray result can never be matched against a request that only
	// arrived at the same edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		queue_result_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: data_out %h source_producer %0d status %0d",
					$time, data_out, source_producer, status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (data_out !== want.data) begin
					$display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
					error_count++;
				end
				if (source_producer !== want.src) begin
					$display("%0t: source_producer expected %0d actual %0d",
						$time, want.src, source_producer);
					error_count++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					error_count++;
				end
				case (want.st)
				STATUS_EMPTY: deq_empty_count++;
				STATUS_FULL:  enq_full_count++;
				default: ;
				endcase
			end
		end
		if (in_valid && in_ready) begin
			want = predict_request(req_type, producer_id, data_in);
			if (want.st == STATUS_DONE) begin
				if (req_type == REQ_ENQ)
					enq_done_count++;
				else
					deq_done_count++;
			end
			pending_results.push_back(want);
		end
		if (in_valid && !in_ready)
			input_stall_cycles++;
		if (cfg_valid && cfg_ready) begin
			enable_shadow = cfg_data;
			cfg_write_count++;
		end
	end

	// Watchdog: give up when no word has moved on any channel for too long
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, pending_results.size());
			$display("timestamp_ordered_multi_queue_unit_test NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: mostly ready, with short stalls and now and then a long one;
	// eager mode holds ready high, a hold-off holds it low
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_holding) begin
			out_ready <= 1'b0;
		end else if (rx_stall_left != 0) begin
			out_ready <= 1'b0;
			rx_stall_left = rx_stall_left - 1;
		end else if (rx_eager) begin
			out_ready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 65) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				if (rx_roll < 95)
					rx_stall_left = $urandom_range(0, 3);
				else
					rx_stall_left = $urandom_range(15, 40);
			end
		end
	end

	// Long receiver hold-off, counted here so the sender can keep pushing
	always begin
		@(start_hold_off);
		rx_holding <= 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		rx_holding <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Sender helpers; all of them start and end at a falling edge
	// ------------------------------------------------------------------
	function automatic int unsigned sender_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 16)
			return '1;
		return $urandom();
	endfunction

	// Offer one request word and hold it until the block takes it. Valid is
	// left high afterwards so a back-to-back word needs no drop in between.
	task automatic send_request(input logic kind, input logic [PID_W-1:0] pid,
			input logic [WORD_W-1:0] word);
		int unsigned gap;
		gap = tx_eager ? 0 : sender_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		producer_id <= pid;
		data_in     <= word;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_enable(input logic [ENABLE_W-1:0] mask);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= mask;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random mix; enq_pct sets how hard the FIFOs are pushed towards full
	task automatic run_random(input int count, input int unsigned enq_pct);
		logic kind;
		for (int i = 0; i < count; i++) begin
			kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
			send_request(kind, PID_W'($urandom_range(0, NUM_PRODUCERS - 1)), random_word());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Dequeue with nothing stored, then oldest-first order across producers
	// at the data extremes; the producer field of a dequeue must be ignored
	task automatic test_empty_and_order();
		send_request(REQ_DEQ, 3'd5, 32'hDEAD_BEEF);
		send_request(REQ_ENQ, 3'd0, 32'h0000_0000);
		send_request(REQ_ENQ, 3'd7, 32'hFFFF_FFFF);
		send_request(REQ_ENQ, 3'd3, 32'hA5A5_A5A5);
		send_request(REQ_DEQ, 3'd7, 32'h0000_0000);
		send_request(REQ_DEQ, 3'd0, 32'hFFFF_FFFF);
		send_request(REQ_DEQ, 3'd2, 32'h5A5A_5A5A);
		send_request(REQ_DEQ, 3'd1, 32'h1234_5678);
	endtask

	// Fill one FIFO to the brim; the next enqueue is rejected and stores nothing
	task automatic test_full_reject();
		for (int i = 0; i < FIFO_DEPTH; i++)
			send_request(REQ_ENQ, 3'd5, random_word());
		send_request(REQ_ENQ, 3'd5, 32'hCAFE_F00D);
	endtask

	// Dequeue scans under several enable masks, the extremes among them
	task automatic test_enable_mask();
		write_enable(8'h00);
		run_random(80, 60);
		write_enable(8'h01);
		run_random(60, 40);
		write_enable(8'h80);
		run_random(60, 40);
		for (int i = 0; i < 3; i++) begin
			write_enable(ENABLE_W'($urandom()));
			run_random(60, 50);
		end
	endtask

	// Broad random traffic with all producers enabled: balanced, draining
	// towards empty, filling towards full, and one stretch with no idling
	task automatic test_random_mix();
		write_enable(8'hFF);
		run_random(220, 50);
		run_random(120, 25);
		run_random(120, 75);
		wait_idle();
		tx_eager  = 1'b1;
		rx_eager <= 1'b1;
		run_random(80, 50);
		wait_idle();
		tx_eager  = 1'b0;
		rx_eager <= 1'b0;
	endtask

	// Hold the receiver off while the sender keeps pushing, so the block
	// fills and throttles its input, then let everything drain
	task automatic test_output_stall();
		-> start_hold_off;
		tx_eager = 1'b1;
		run_random(60, 50);
		tx_eager = 1'b0;
		wait_idle();
	endtask

	// Pause the sender until every result is back, then carry on
	task automatic test_drain_pause();
		run_random(40, 55);
		wait_idle();
		run_random(40, 45);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_and_order();
		test_full_reject();
		test_enable_mask();
		test_random_mix();
		test_output_stall();
		test_drain_pause();

		wait_idle();
		repeat (DRAIN_PAUSE_CYCLES) @(negedge clk);

		$display("covered %0d enqueues stored, %0d rejected as full, %0d dequeues served, %0d empty",
			enq_done_count, enq_full_count, deq_done_count, deq_empty_count);
		$display("across %0d enable-mask writes, with %0d cycles of input back-pressure",
			cfg_write_count, input_stall_cycles);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("timestamp_ordered_multi_queue_unit_test OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				error_count, pending_results.size());
			$display("timestamp_ordered_multi_queue_unit_test NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/tomq_pkg.sv
src/tomq_front.sv
src/tomq_back.sv
src/timestamp_ordered_multi_queue_unit.sv
src/tomq_checker.sv
sim/timestamp_ordered_multi_queue_unit_test.sv
